@@ rtl/bcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Beat receiver clock sync package
// Shared widths, register indexes and reset values of the offset filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bcs_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned BeatW     = 16;
  localparam int unsigned ThrW      = 31;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 112;
  localparam int unsigned OutDataW  = 120;

  localparam logic [CountW-1:0] SampleCountMax = 16'hFFFF;

  localparam logic [ThrW-1:0]   SnapThrReset    = 31'd1000;
  localparam logic [TimeW-1:0]  WindowReset     = 32'd2000;
  localparam logic [CountW-1:0] MinSamplesReset = 16'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSnapThr    = 2'd0,
    CfgWindow     = 2'd1,
    CfgMinSamples = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ rtl/beat_receiver_clock_sync.sv @@
// ----------------------------------------------------------------------------
// Beat receiver clock sync
// Minimum-delay clock offset filter with beat deduplication and pending beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each packet handled by software is pushed as one beat on the slave stream:
//   tuser carries the packet kind (0 control, 1 beat), tdata the master stamp,
//   the local time, the beat number and the play time. Every input beat gives
//   exactly one result beat on the master stream with the offset estimate,
//   the converged / snapped / accepted / duplicate flags and the pending beat.
//   Configuration (snap threshold, window length, min samples) is written
//   through the cfg channel while the block is idle; cfg_ready_o is always 1.
//   An accepted input beat is captured in the input register, and its result
//   is then loaded into the result register once that register is free or
//   drains. Throughput: one beat per cycle while the receiver takes results;
//   the whole filter update is a single pass of compares and adds between the
//   input register and the state/result registers.
//   Reset clears the filter state, the pending beat and both stream stages,
//   and loads the default configuration. When the receiver stalls, the result
//   register holds, the input register takes one more beat, then s_axis_tready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module beat_receiver_clock_sync (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // slave stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: master_stamp_ms[31:0], local_time_ms[63:32], beat_number[79:64],
  //        play_at_ms[111:80]
  input  wire logic [bcs_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: op[0]
  input  wire logic                          s_axis_tuser,
  // master stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: offset_ms[31:0], converged[32], snapped[33], beat_accepted[34],
  //        beat_duplicate[35], pending_valid[36], pending_beat[52:37],
  //        pending_play_ms[84:53], pending_enqueued_ms[116:85], zero[119:117]
  output logic [bcs_pkg::OutDataW-1:0]       m_axis_tdata,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bcs_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned TW = bcs_pkg::TimeW;
  localparam int unsigned BW = bcs_pkg::BeatW;
  localparam int unsigned CW = bcs_pkg::CountW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [bcs_pkg::ThrW-1:0] snap_thr_q;
  logic [TW-1:0]            window_q;
  logic [CW-1:0]            min_samples_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_thr_q    <= bcs_pkg::SnapThrReset;
      window_q      <= bcs_pkg::WindowReset;
      min_samples_q <= bcs_pkg::MinSamplesReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bcs_pkg::CfgSnapThr:    snap_thr_q    <= cfg_data_i[bcs_pkg::ThrW-1:0];
        bcs_pkg::CfgWindow:     window_q      <= cfg_data_i[TW-1:0];
        bcs_pkg::CfgMinSamples: min_samples_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic          in_valid_q;
  logic          op_q;
  logic [TW-1:0] master_q;
  logic [TW-1:0] local_q;
  logic [BW-1:0] bn_q;
  logic [TW-1:0] play_q;
  logic          out_valid_q;
  logic          fire;
  logic          in_take;

  // Advance the update stage whenever the result register is free or drains.
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q     <= s_axis_tuser;
      master_q <= s_axis_tdata[TW-1:0];
      local_q  <= s_axis_tdata[2*TW-1:TW];
      bn_q     <= s_axis_tdata[2*TW+BW-1:2*TW];
      play_q   <= s_axis_tdata[3*TW+BW-1:2*TW+BW];
    end
  end

  // --------------------------------------------------------------------------
  // Filter and beat state
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] offset_q, offset_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 conv_q, conv_d;
  logic                 win_open_q, win_open_d;
  logic [TW-1:0]        win_start_q, win_start_d;
  logic signed [TW-1:0] win_max_q, win_max_d;
  logic                 seen_q, seen_d;
  logic [BW-1:0]        last_bn_q, last_bn_d;
  logic                 pend_q, pend_d;
  logic [BW-1:0]        pend_bn_q, pend_bn_d;
  logic [TW-1:0]        pend_play_q, pend_play_d;
  logic [TW-1:0]        pend_enq_q, pend_enq_d;

  logic signed [TW-1:0] sample;
  logic signed [TW:0]   jump;
  logic signed [TW:0]   thr_pos;
  logic signed [TW:0]   thr_neg;
  logic                 first_sample;
  logic                 snap;
  logic                 dup;
  logic                 accept;
  logic [TW-1:0]        win_age;
  logic [CW-1:0]        count_base;
  logic signed [TW-1:0] win_max_new;

  always_comb begin
    sample       = signed'(master_q - local_q);
    jump         = {sample[TW-1], sample} - {offset_q[TW-1], offset_q};
    thr_pos      = signed'({2'b00, snap_thr_q});
    thr_neg      = -thr_pos;
    first_sample = (count_q == '0);
    snap         = !first_sample && ((jump > thr_pos) || (jump < thr_neg));
    win_age      = local_q - win_start_q;
    win_max_new  = (sample > win_max_q) ? sample : win_max_q;

    offset_d    = offset_q;
    win_open_d  = win_open_q;
    win_start_d = win_start_q;
    win_max_d   = win_max_q;
    conv_d      = conv_q;

    if (first_sample) begin
      offset_d   = sample;
      win_open_d = 1'b0;
    end else if (snap) begin
      offset_d   = sample;
      conv_d     = 1'b0;
      win_open_d = 1'b0;
    end else begin
      // Take a larger sample at once: it came with less path delay.
      if (sample > offset_q) offset_d = sample;
      if (!win_open_q) begin
        win_open_d  = 1'b1;
        win_start_d = local_q;
        win_max_d   = sample;
      end else begin
        win_max_d = win_max_new;
        if (win_age >= window_q) begin
          offset_d   = win_max_new;
          win_open_d = 1'b0;
        end
      end
    end

    // Restart the count on a snap, then count this sample with saturation.
    count_base = snap ? '0 : count_q;
    count_d    = (count_base < bcs_pkg::SampleCountMax) ? count_base + 1'b1 : count_base;
    if (count_d >= min_samples_q) conv_d = 1'b1;

    // Beat deduplication; a snap drops the pending beat and its history.
    dup         = op_q && seen_q && (bn_q == last_bn_q) && !snap;
    seen_d      = snap ? 1'b0 : seen_q;
    last_bn_d   = snap ? '0 : last_bn_q;
    pend_d      = snap ? 1'b0 : pend_q;
    pend_bn_d   = pend_bn_q;
    pend_play_d = pend_play_q;
    pend_enq_d  = pend_enq_q;
    accept      = op_q && !dup;
    if (accept) begin
      pend_d      = 1'b1;
      pend_bn_d   = bn_q;
      pend_play_d = play_q;
      pend_enq_d  = local_q;
      last_bn_d   = bn_q;
      seen_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      count_q     <= '0;
      conv_q      <= 1'b0;
      win_open_q  <= 1'b0;
      win_start_q <= '0;
      win_max_q   <= '0;
      seen_q      <= 1'b0;
      last_bn_q   <= '0;
      pend_q      <= 1'b0;
      pend_bn_q   <= '0;
      pend_play_q <= '0;
      pend_enq_q  <= '0;
    end else if (fire) begin
      offset_q    <= offset_d;
      count_q     <= count_d;
      conv_q      <= conv_d;
      win_open_q  <= win_open_d;
      win_start_q <= win_start_d;
      win_max_q   <= win_max_d;
      seen_q      <= seen_d;
      last_bn_q   <= last_bn_d;
      pend_q      <= pend_d;
      pend_bn_q   <= pend_bn_d;
      pend_play_q <= pend_play_d;
      pend_enq_q  <= pend_enq_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [bcs_pkg::OutDataW-1:0] out_data_q;
  logic [bcs_pkg::OutDataW-1:0] out_data_d;

  assign out_data_d = {3'b000, pend_enq_d, pend_play_d, pend_bn_d, pend_d,
                       dup, accept, snap, conv_d, offset_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An accepted beat always leaves a pending reservation.
  a_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[34]) |-> m_axis_tdata[36])
    else $error("accepted beat without pending reservation");

  // A beat is never both accepted and a duplicate.
  a_accept_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[34] && m_axis_tdata[35]))
    else $error("beat accepted and duplicate at once");

  // A snap wipes beat history, so it cannot flag a duplicate.
  a_snap_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33]) |-> !m_axis_tdata[35])
    else $error("snap reported with duplicate beat");

  // Every processed sample leaves a nonzero sample count.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (count_q != '0))
    else $error("sample count zero after update");

  // A processed beat always lands in the result register.
  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result lost after update");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Beat receiver clock sync testbench
// Streams control and beat packets into the offset filter and tracks the
// filter, the beat deduplication and the pending beat in a bench-side model.
// Every result beat is checked field by field against the model. The run
// mixes directed corner packets, random sessions under several register
// settings, a long receiver stall and a steady back-to-back run.
// ----------------------------------------------------------------------------

module tb_top;
  import bcs_pkg::*;

  localparam int unsigned StuckLimit = 2000;   // cycles without any handshake
  localparam int unsigned LongHold   = 80;     // receiver hold-off, cycles
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned SteadyItems = 40;    // steady run, no idling

  typedef enum bit {
    PktControl = 1'b0,
    PktBeat    = 1'b1
  } pkt_kind_e;

  typedef struct {
    pkt_kind_e  kind;
    bit [31:0]  stamp_ms;
    bit [31:0]  local_ms;
    bit [15:0]  beat_no;
    bit [31:0]  play_ms;
  } packet_t;

  typedef struct {
    bit [31:0]  offset_ms;
    bit         converged;
    bit         snapped;
    bit         accepted;
    bit         duplicate;
    bit         pend_valid;
    bit [15:0]  pend_beat;
    bit [31:0]  pend_play;
    bit [31:0]  pend_enq;
  } sync_res_t;

  // DUT connections, all inputs known from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  cfg_idx_e            cfg_index_i   = CfgSnapThr;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Bench-side copy of the configuration and filter state
  bit [ThrW-1:0]         cur_snap_thr    = SnapThrReset;
  bit [TimeW-1:0]        cur_window      = WindowReset;
  bit [CountW-1:0]       cur_min_samples = MinSamplesReset;
  bit signed [TimeW-1:0] est_offset      = '0;
  bit [CountW-1:0]       sample_cnt      = '0;
  bit                    est_converged   = 1'b0;
  bit                    win_open        = 1'b0;
  bit [TimeW-1:0]        win_start       = '0;
  bit signed [TimeW-1:0] win_max         = '0;
  bit                    beat_seen       = 1'b0;
  bit [BeatW-1:0]        last_beat       = '0;
  bit                    hold_valid      = 1'b0;
  bit [BeatW-1:0]        hold_beat       = '0;
  bit [TimeW-1:0]        hold_play       = '0;
  bit [TimeW-1:0]        hold_enq        = '0;

  packet_t     pkt_q[$];          // packets waiting to be offered
  sync_res_t   exp_offset_q[$];   // results owed by the block, oldest first

  int unsigned fails        = 0;
  int unsigned stuck_cycles = 0;
  bit          in_taken     = 1'b0;
  bit          idle_on      = 1'b0;
  bit          hold_req     = 1'b0;
  int unsigned tx_gap       = 0;
  int unsigned rx_gap       = 0;
  int unsigned rx_hold      = 0;

  always #4 clk_i = ~clk_i;

  beat_receiver_clock_sync i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Advance the bench filter by one packet and return the result it owes.
  function automatic sync_res_t predict_offset_result(packet_t p);
    sync_res_t             r;
    bit signed [TimeW-1:0] sample;
    bit [TimeW-1:0]        age;
    longint                jump;
    longint                thr;
    bit                    snap;
    bit                    dup;
    bit                    acc;
    sample = p.stamp_ms - p.local_ms;
    thr    = longint'(cur_snap_thr);
    snap   = 1'b0;
    dup    = 1'b0;
    acc    = 1'b0;
    if (p.kind == PktBeat) dup = beat_seen && (p.beat_no == last_beat);

    if (sample_cnt == '0) begin
      // first sample ever: take it as is, no snap
      est_offset = sample;
      win_open   = 1'b0;
    end else begin
      // jump is the exact difference, no 32-bit wrap
      jump = longint'(sample) - longint'(est_offset);
      if (jump > thr || jump < -thr) begin
        est_offset    = sample;
        sample_cnt    = '0;
        est_converged = 1'b0;
        win_open      = 1'b0;
        snap          = 1'b1;
      end else begin
        if (sample > est_offset) est_offset = sample;
        if (!win_open) begin
          win_open  = 1'b1;
          win_start = p.local_ms;
          win_max   = sample;
        end else begin
          if (sample > win_max) win_max = sample;
          age = p.local_ms - win_start;
          if (age >= cur_window) begin
            est_offset = win_max;
            win_open   = 1'b0;
          end
        end
      end
    end
    if (sample_cnt != SampleCountMax) sample_cnt++;
    if (sample_cnt >= cur_min_samples) est_converged = 1'b1;

    // a snap drops the pending beat and forgets beat history
    if (snap) begin
      hold_valid = 1'b0;
      beat_seen  = 1'b0;
      last_beat  = '0;
      dup        = 1'b0;
    end
    if (p.kind == PktBeat && !dup) begin
      hold_valid = 1'b1;
      hold_beat  = p.beat_no;
      hold_play  = p.play_ms;
      hold_enq   = p.local_ms;
      last_beat  = p.beat_no;
      beat_seen  = 1'b1;
      acc        = 1'b1;
    end

    r.offset_ms  = est_offset;
    r.converged  = est_converged;
    r.snapped    = snap;
    r.accepted   = acc;
    r.duplicate  = dup;
    r.pend_valid = hold_valid;
    r.pend_beat  = hold_beat;
    r.pend_play  = hold_play;
    r.pend_enq   = hold_enq;
    return r;
  endfunction

  function automatic void check_field(string name, bit [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Monitor: sample every handshake at the rising edge, keep the model in
  // step and check result beats. Also runs the stall watchdog.
  always @(posedge clk_i) begin : monitor
    packet_t   acc_pkt;
    sync_res_t want;
    bit        progress;
    progress = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      progress = 1'b1;
      case (cfg_index_i)
        CfgSnapThr:    cur_snap_thr    = cfg_data_i[ThrW-1:0];
        CfgWindow:     cur_window      = cfg_data_i;
        CfgMinSamples: cur_min_samples = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready) begin
      progress = 1'b1;
      acc_pkt  = pkt_q.pop_front();
      exp_offset_q.push_back(predict_offset_result(acc_pkt));
      in_taken = 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      progress = 1'b1;
      if (exp_offset_q.size() == 0) begin
        fails++;
        $display("%0t: result beat with nothing expected, actual %h", $time, m_axis_tdata);
      end else begin
        want = exp_offset_q.pop_front();
        check_field("offset_ms",           want.offset_ms,       m_axis_tdata[31:0]);
        check_field("converged",           32'(want.converged),  32'(m_axis_tdata[32]));
        check_field("snapped",             32'(want.snapped),    32'(m_axis_tdata[33]));
        check_field("beat_accepted",       32'(want.accepted),   32'(m_axis_tdata[34]));
        check_field("beat_duplicate",      32'(want.duplicate),  32'(m_axis_tdata[35]));
        check_field("pending_valid",       32'(want.pend_valid), 32'(m_axis_tdata[36]));
        check_field("pending_beat",        32'(want.pend_beat),  32'(m_axis_tdata[52:37]));
        check_field("pending_play_ms",     want.pend_play,       m_axis_tdata[84:53]);
        check_field("pending_enqueued_ms", want.pend_enq,        m_axis_tdata[116:85]);
      end
    end
    stuck_cycles = progress ? 0 : stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, StuckLimit);
      $display("FAIL");
      $finish;
    end
  end

  // Packet driver: hold a beat until it is taken, then offer the next one
  // or idle for a random burst.
  always @(negedge clk_i) begin : pkt_driver
    if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (tx_gap != 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pkt_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pkt_q[0].play_ms, pkt_q[0].beat_no,
                          pkt_q[0].local_ms, pkt_q[0].stamp_ms};
        s_axis_tuser  <= pkt_q[0].kind;
        if (idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 14);
      end
    end
  end

  // Result sink: random stall bursts, plus one long hold-off on request.
  always @(negedge clk_i) begin : result_sink
    if (hold_req) begin
      hold_req = 1'b0;
      rx_hold  = LongHold;
    end
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 14);
    end
  end

  task automatic push_pkt(pkt_kind_e kind, bit [31:0] stamp, bit [31:0] local_ms,
                          bit [15:0] beat_no, bit [31:0] play);
    packet_t p;
    p.kind     = kind;
    p.stamp_ms = stamp;
    p.local_ms = local_ms;
    p.beat_no  = beat_no;
    p.play_ms  = play;
    pkt_q.push_back(p);
  endtask

  task automatic cfg_write(cfg_idx_e idx, bit [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every packet is taken and every result has come back.
  task automatic wait_drained();
    while (pkt_q.size() != 0 || exp_offset_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Queue a session of packets from one master clock: a slowly drifting
  // offset with random delay, beats mostly in sequence with some repeats,
  // occasional offset jumps and a few packets of pure noise.
  task automatic queue_session(int unsigned count);
    packet_t     p;
    bit [31:0]   clock_ms;
    bit [31:0]   true_off;
    bit [15:0]   beat_no;
    int unsigned roll;
    clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                           : $urandom;
    true_off = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 5000) - 2500;
    beat_no  = $urandom;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        p.kind     = pkt_kind_e'($urandom_range(0, 1));
        p.stamp_ms = $urandom;
        p.local_ms = $urandom;
        p.beat_no  = $urandom;
        p.play_ms  = $urandom;
      end else begin
        if (roll < 9) true_off = $urandom;
        else if (roll < 25) true_off = true_off + $urandom_range(0, 20) - 10;
        clock_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5000)
                                                : $urandom_range(0, 60);
        p.kind = ($urandom_range(0, 1) == 0) ? PktControl : PktBeat;
        // leave the number alone now and then to make a repeat
        if (p.kind == PktBeat && $urandom_range(0, 3) != 0)
          beat_no += ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'd1;
        p.local_ms = clock_ms;
        p.stamp_ms = clock_ms + true_off - $urandom_range(0, 40);
        p.beat_no  = (p.kind == PktBeat) ? beat_no : 16'($urandom);
        p.play_ms  = p.stamp_ms + $urandom_range(0, 2000);
      end
      pkt_q.push_back(p);
    end
  endtask

  initial begin : stimulus
    bit [31:0]   thr_menu [6];
    bit [31:0]   win_menu [6];
    bit [31:0]   min_menu [6];
    bit [31:0]   base_ms;
    int unsigned sel;
    int unsigned k;
    thr_menu = '{32'd0, 32'd1, 32'd20, 32'd1000, 32'h7FFF_FFFF, 32'd0};
    win_menu = '{32'd0, 32'd1, 32'd50, 32'd2000, 32'hFFFF_FFFF, 32'd0};
    min_menu = '{32'd0, 32'd1, 32'd4, 32'd8, 32'h0000_FFFF, 32'd0};

    repeat (9) @(negedge clk_i);
    rst_ni  <= 1'b1;
    idle_on = 1'b1;

    // Reset settings: first sample, dedup, snaps at the threshold edges,
    // window expiry including a local time wrap.
    push_pkt(PktControl, 32'd1000, 32'd0, 16'h0000, 32'h0000_0000);
    push_pkt(PktBeat,    32'd1000, 32'd1000, 16'h0000, 32'h0000_0000);
    push_pkt(PktBeat,    32'd1500, 32'd1000, 16'h0000, 32'd1234);
    push_pkt(PktBeat,    32'd2000, 32'd1000, 16'hFFFF, 32'hFFFF_FFFF);
    push_pkt(PktControl, 32'd3001, 32'd1000, 16'h1234, 32'h5555_AAAA);
    push_pkt(PktControl, 32'd2001, 32'd1000, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'd4001, 32'd1000, 16'h0000, 32'h0000_0000);
    push_pkt(PktBeat,    32'd4001, 32'd1001, 16'hFFFF, 32'd500);
    push_pkt(PktBeat,    32'd4001, 32'd1002, 16'hFFFF, 32'd600);
    push_pkt(PktBeat,    32'd0,    32'd1003, 16'hFFFF, 32'd700);
    push_pkt(PktControl, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_pkt(PktControl, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'hFFFF_FF00, 32'hFFFF_FF00, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'h0000_06FF, 32'h0000_0700, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'd2000, 32'd2000, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'd4000, 32'd3999, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'd3995, 32'd4000, 16'h0000, 32'h0000_0000);
    push_pkt(PktBeat,    32'd4001, 32'd4000, 16'h8000, 32'h8000_0000);
    wait_drained();

    // Widest threshold, zero window, zero min samples: jumps across the
    // signed range and exactly at the threshold.
    cfg_write(CfgSnapThr,    32'hFFFF_FFFF);
    cfg_write(CfgWindow,     32'h0000_0000);
    cfg_write(CfgMinSamples, 32'hFFFF_0000);
    push_pkt(PktControl, 32'h7FFF_FFFF, 32'd0, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'h8000_0000, 32'd0, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'h7FFF_FFFF, 32'd0, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'hFFFF_FFFF, 32'd0, 16'h0000, 32'h0000_0000);
    push_pkt(PktControl, 32'h0000_0000, 32'd0, 16'h0000, 32'h0000_0000);
    push_pkt(PktBeat,    32'd5,         32'd3, 16'h0001, 32'd10);
    push_pkt(PktControl, 32'h8000_0003, 32'd0, 16'h0000, 32'h0000_0000);
    wait_drained();

    // Random sessions; the first phases walk the register extremes together.
    for (int unsigned pi = 0; pi < NumPhases; pi++) begin
      thr_menu[5] = $urandom;
      win_menu[5] = $urandom_range(0, 3000);
      min_menu[5] = $urandom_range(0, 20);
      idle_on     = (pi % 3 != 1);
      sel = (pi < 5) ? pi : $urandom_range(0, 5);
      cfg_write(CfgSnapThr, {1'($urandom), thr_menu[sel][30:0]});
      sel = (pi < 5) ? pi : $urandom_range(0, 5);
      cfg_write(CfgWindow, win_menu[sel]);
      sel = (pi < 5) ? pi : $urandom_range(0, 5);
      cfg_write(CfgMinSamples, {16'($urandom), min_menu[sel][15:0]});
      queue_session(PhaseItems);
      if (pi == 2) begin
        // stall the receiver while the sender keeps offering
        @(posedge clk_i);
        hold_req = 1'b1;
      end
      wait_drained();
    end

    // Last part, no idling: a steady offset run of back-to-back beats,
    // then carry on with random sessions.
    idle_on = 1'b0;
    cfg_write(CfgSnapThr,    32'h7FFF_FFFF);
    cfg_write(CfgWindow,     32'hFFFF_FFFF);
    cfg_write(CfgMinSamples, 32'h0000_FFFF);
    base_ms = $urandom;
    for (k = 0; k < SteadyItems; k++)
      push_pkt(pkt_kind_e'(k[0]), base_ms + k + 32'd7000 - $urandom_range(0, 3),
               base_ms + k, k[16:1], base_ms + k + 32'd9000);
    queue_session(60);
    wait_drained();

    cfg_write(CfgSnapThr,    {1'b0, SnapThrReset});
    cfg_write(CfgWindow,     WindowReset);
    cfg_write(CfgMinSamples, {16'h0000, MinSamplesReset});
    queue_session(PhaseItems);
    wait_drained();

    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
